@@ hw/rtl/tlpt_pkg.sv @@
// Shared types, codes and sizes for the two-level page table mapper.
package tlpt_pkg;

   localparam int POOL_TABLES_DEFAULT = 16;
   localparam int ENTRIES_PER_TABLE   = 1024;
   localparam int ROOT_ENTRIES        = 1024;
   localparam int INDEX_W             = 10;
   localparam int ROOT_SHIFT          = 22;
   localparam int PAGE_SHIFT          = 12;
   localparam int HEAP_START_W        = 20;
   localparam int HEAP_END_W          = 21;
   localparam int PAGE_CNT_W          = 21;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 21;

   localparam logic [2:0] ALIGN_MASK = 3'h7;
   localparam logic [HEAP_END_W-1:0] HEAP_END_RESET = 21'h100000;

   // Request kinds.
   localparam logic [1:0] KIND_MAP    = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_ALLOC  = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_UNALIGNED_VA = 3'd1;
   localparam logic [2:0] ST_UNALIGNED_PA = 3'd2;
   localparam logic [2:0] ST_NO_MEMORY    = 3'd3;
   localparam logic [2:0] ST_NOT_MAPPED   = 3'd4;
   localparam logic [2:0] ST_POOL_FULL    = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_END   = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] virtual_address;
      logic [31:0] physical_address;
      logic [9:0]  flag_bits;
      logic [10:0] page_count;
   } req_type;

   typedef struct packed {
      logic [31:0] entry_value;
      logic [31:0] allocated_address;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic eval;
      logic leaf_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic lookup_hit;
   } dp_status_type;

endpackage

@@ hw/rtl/tlpt_ctrl.sv @@
// Sequencing state machine for the page table mapper.
module tlpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tlpt_pkg::dp_status_type dp_status,
   output tlpt_pkg::ctrl_cmd_type  cmd,
   output logic                    busy
);
   import tlpt_pkg::*;

   localparam logic [1:0] FSM_CLEAR = 2'd0;
   localparam logic [1:0] FSM_IDLE  = 2'd1;
   localparam logic [1:0] FSM_EVAL  = 2'd2;
   localparam logic [1:0] FSM_LEAF  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = reset | (state_ff != FSM_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         FSM_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_status.clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (start && !busy) begin
               cmd.capture = 1'b1;
               state_in    = FSM_EVAL;
            end
         end
         FSM_EVAL: begin
            cmd.eval = 1'b1;
            state_in = dp_status.lookup_hit ? FSM_LEAF : FSM_IDLE;
         end
         FSM_LEAF: begin
            cmd.leaf_load = 1'b1;
            state_in      = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/tlpt_datapath.sv @@
// Datapath of the mapper: tables, allocator counters, config and result registers.
module tlpt_datapath #(
   parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tlpt_pkg::ctrl_cmd_type                 cmd,
   output tlpt_pkg::dp_status_type                dp_status,
   input  tlpt_pkg::req_type                      req,
   output logic                                   rsp_valid,
   output tlpt_pkg::rsp_type                      rsp,
   input  logic                                   csr_we,
   input  logic [tlpt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tlpt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import tlpt_pkg::*;

   localparam int SLOT_W     = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int LEAF_DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
   localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
   localparam int TABLE_W    = $clog2(POOL_TABLES + 1);

   // Root entry: valid bit above the pool slot of its second-level table.
   logic [SLOT_W:0]     root_mem [ROOT_ENTRIES];
   logic [31:0]         leaf_mem [LEAF_DEPTH];

   req_type             req_ff;
   logic [SLOT_W:0]     root_rd_ff;
   logic [31:0]         leaf_rd_ff;
   logic [LEAF_AW-1:0]  clear_cnt_ff;
   logic [HEAP_START_W-1:0] heap_start_ff;
   logic [HEAP_END_W-1:0]   heap_end_ff;
   logic [PAGE_CNT_W-1:0]   pages_used_ff;
   logic [TABLE_W-1:0]      tables_used_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [INDEX_W-1:0]  root_idx;
   logic [INDEX_W-1:0]  leaf_col;
   logic                root_valid;
   logic [SLOT_W-1:0]   new_slot;
   logic [SLOT_W-1:0]   leaf_slot;
   logic [SLOT_W+INDEX_W-1:0] leaf_full_idx;
   logic [LEAF_AW-1:0]  leaf_addr;
   logic                va_unal;
   logic                pa_unal;
   logic [10:0]         alloc_n;
   logic [21:0]         base_page;
   logic [22:0]         top_page;
   logic                fits;
   logic                pool_full;
   logic [31:0]         map_entry;
   rsp_type             eval_rsp;
   logic                map_ok;
   logic                commit_pages;
   logic                lookup_hit;
   logic                root_wr;
   logic                leaf_wr;
   logic                leaf_rd;

   assign root_idx      = req_ff.virtual_address[31:ROOT_SHIFT];
   assign leaf_col      = req_ff.virtual_address[ROOT_SHIFT-1:PAGE_SHIFT];
   assign root_valid    = root_rd_ff[SLOT_W];
   assign new_slot      = tables_used_ff[SLOT_W-1:0];
   assign leaf_slot     = root_valid ? root_rd_ff[SLOT_W-1:0] : new_slot;
   assign leaf_full_idx = {leaf_slot, leaf_col};
   assign leaf_addr     = leaf_full_idx[LEAF_AW-1:0];

   assign va_unal   = |(req_ff.virtual_address[2:0] & ALIGN_MASK);
   assign pa_unal   = |(req_ff.physical_address[2:0] & ALIGN_MASK);
   assign alloc_n   = (req_ff.kind == KIND_MAP) ? 11'd1 : req_ff.page_count;
   assign base_page = {2'b00, heap_start_ff} + {1'b0, pages_used_ff};
   assign top_page  = {1'b0, base_page} + {12'b0, alloc_n};
   assign fits      = top_page <= {2'b00, heap_end_ff};
   assign pool_full = tables_used_ff == TABLE_W'(POOL_TABLES);
   assign map_entry = {2'b00, req_ff.physical_address[31:PAGE_SHIFT],
                       req_ff.flag_bits | 10'd1};

   always_comb begin
      eval_rsp     = '0;
      map_ok       = 1'b0;
      commit_pages = 1'b0;
      lookup_hit   = 1'b0;
      case (req_ff.kind)
         KIND_MAP: begin
            if (va_unal) begin
               eval_rsp.status = ST_UNALIGNED_VA;
            end else if (pa_unal) begin
               eval_rsp.status = ST_UNALIGNED_PA;
            end else if (!root_valid && pool_full) begin
               eval_rsp.status = ST_POOL_FULL;
            end else if (!root_valid && !fits) begin
               eval_rsp.status = ST_NO_MEMORY;
            end else begin
               eval_rsp.entry_value = map_entry;
               map_ok               = 1'b1;
               commit_pages         = !root_valid;
            end
         end
         KIND_LOOKUP: begin
            if (va_unal) begin
               eval_rsp.status = ST_UNALIGNED_VA;
            end else if (!root_valid) begin
               eval_rsp.status = ST_NOT_MAPPED;
            end else begin
               lookup_hit = 1'b1;
            end
         end
         KIND_ALLOC: begin
            if (fits) begin
               eval_rsp.allocated_address = {base_page[19:0], 12'h000};
               commit_pages               = 1'b1;
            end else begin
               eval_rsp.status = ST_NO_MEMORY;
            end
         end
         default: begin
            eval_rsp = '0;
         end
      endcase
   end

   assign leaf_wr = cmd.eval & map_ok;
   assign root_wr = cmd.eval & map_ok & ~root_valid;
   assign leaf_rd = cmd.eval & lookup_hit;

   assign dp_status.clear_last = clear_cnt_ff == LEAF_AW'(LEAF_DEPTH - 1);
   assign dp_status.lookup_hit = lookup_hit;

   // Root table: cleared by the sweep, written when a map claims a new table, read when a request is taken.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         root_mem[clear_cnt_ff[INDEX_W-1:0]] <= '0;
      end else if (root_wr) begin
         root_mem[root_idx] <= {1'b1, new_slot};
      end
      if (cmd.capture) begin
         root_rd_ff <= root_mem[req.virtual_address[31:ROOT_SHIFT]];
      end
   end

   // Leaf table store, one port.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         leaf_mem[clear_cnt_ff] <= '0;
      end else if (leaf_wr) begin
         leaf_mem[leaf_addr] <= map_entry;
      end
      if (leaf_rd) begin
         leaf_rd_ff <= leaf_mem[leaf_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
   end

   always_comb begin
      if (cmd.eval) begin
         rsp_in = eval_rsp;
      end else begin
         rsp_in                   = '0;
         rsp_in.entry_value       = leaf_rd_ff;
         rsp_in.status            = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.eval && !lookup_hit) || cmd.leaf_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff   <= '0;
         heap_start_ff  <= '0;
         heap_end_ff    <= HEAP_END_RESET;
         pages_used_ff  <= '0;
         tables_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + LEAF_AW'(1);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HEAP_START: heap_start_ff <= csr_wdata[HEAP_START_W-1:0];
               CSR_HEAP_END:   heap_end_ff   <= csr_wdata[HEAP_END_W-1:0];
               default:        heap_end_ff   <= heap_end_ff;
            endcase
         end
         if (cmd.eval && commit_pages) begin
            pages_used_ff <= pages_used_ff + PAGE_CNT_W'(alloc_n);
         end
         if (root_wr) begin
            tables_used_ff <= tables_used_ff + TABLE_W'(1);
         end
         rsp_valid_ff <= (cmd.eval && !lookup_hit) || cmd.leaf_load;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      tables_used_ff <= TABLE_W'(POOL_TABLES))
      else $error("table pool count beyond pool size");

   a_pages_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.eval |=> $stable(pages_used_ff))
      else $error("page count changed outside request evaluation");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_leaf_after_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.leaf_load |-> $past(leaf_rd))
      else $error("leaf result loaded without a leaf read");

endmodule

@@ hw/rtl/two_level_page_table_mapper.sv @@
// Top level of the two-level page table mapper.
//
//  channel  | ports                                 | transfer
//  ---------+---------------------------------------+-----------------------------
//  request  | start, busy, req                      | edge with start high, busy low
//  result   | rsp_valid, rsp                        | every cycle rsp_valid is high
//  config   | csr_we, csr_index, csr_wdata          | every edge with csr_we high
//
// Every request but a lookup that finds a table is registered, evaluated in the EVAL
// state with busy high, and its result registered with the strobe. A lookup that
// finds a table goes on to the LEAF state for the read of the one-port leaf store.
// After reset the root table and the leaf store are swept to zero, one entry a
// cycle, busy high until the last leaf entry is clear; config writes still land.
// Results cannot be held off; one result is out before the next request enters.
module two_level_page_table_mapper #(
   parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tlpt_pkg::req_type                  req,
   output logic                               rsp_valid,
   output tlpt_pkg::rsp_type                  rsp,
   input  logic                               csr_we,
   input  logic [tlpt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tlpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tlpt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   tlpt_datapath #(
      .POOL_TABLES (POOL_TABLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_status (dp_status),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ tb/two_level_page_table_mapper_tb.sv @@
// Self-checking testbench for the two-level page table mapper: directed table, then random phases.
module two_level_page_table_mapper_tb;
   import tlpt_pkg::*;

   localparam int POOL_SIZE = POOL_TABLES_DEFAULT;
   localparam int LEAF_DEPTH = POOL_SIZE * ENTRIES_PER_TABLE;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type answer;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req = '0;
   logic                   rsp_valid;
   rsp_type                rsp;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // A typed-in answer travels with the request and replaces the predicted one.
   bit      pin_valid = 1'b0;
   rsp_type pin_rsp = '0;

   // Own copy of the table state and the heap registers.
   logic [31:0]           pt_root[ROOT_ENTRIES];
   logic [3:0]            pt_slot[ROOT_ENTRIES];
   logic [31:0]           pt_leaf[LEAF_DEPTH];
   logic [PAGE_CNT_W-1:0] pt_pages_used;
   int                    pt_tables_used;
   logic [HEAP_START_W-1:0] heap_first;
   logic [HEAP_END_W-1:0]   heap_limit;

   rsp_type      pending_answers[$];
   logic [31:0]  mapped_vas[$];
   logic [9:0]   root_pick[24];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           answers_seen = 0;
   int           cycle_count = 0;

   two_level_page_table_mapper i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("two_level_page_table_mapper regression: fail");
         $finish;
      end
   end

   task automatic clear_tables();
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
         pt_root[i] = '0;
         pt_slot[i] = '0;
      end
      for (int i = 0; i < LEAF_DEPTH; i++) pt_leaf[i] = '0;
      pt_pages_used = '0;
      pt_tables_used = 0;
      heap_first = '0;
      heap_limit = HEAP_END_RESET;
   endtask

   function automatic bit take_pages(input logic [31:0] n, output logic [31:0] first_page);
      logic [31:0] base;
      base = 32'(heap_first) + 32'(pt_pages_used);
      first_page = base;
      if (base + n > 32'(heap_limit)) return 1'b0;
      pt_pages_used = PAGE_CNT_W'(32'(pt_pages_used) + n);
      return 1'b1;
   endfunction

   function automatic rsp_type page_table_step(input req_type item);
      rsp_type     answer;
      logic [9:0]  root;
      logic [13:0] leaf_at;
      logic [31:0] page;
      bit          ready;
      answer = '0;
      root = item.virtual_address[31:ROOT_SHIFT];
      leaf_at = {pt_slot[root], item.virtual_address[21:PAGE_SHIFT]};
      case (item.kind)
         KIND_MAP: begin
            if ((item.virtual_address[2:0] & ALIGN_MASK) != 0) begin
               answer.status = ST_UNALIGNED_VA;
            end else if ((item.physical_address[2:0] & ALIGN_MASK) != 0) begin
               answer.status = ST_UNALIGNED_PA;
            end else begin
               ready = pt_root[root][0];
               if (!ready) begin
                  // The pool check comes before the heap check.
                  if (pt_tables_used >= POOL_SIZE) begin
                     answer.status = ST_POOL_FULL;
                  end else if (!take_pages(32'd1, page)) begin
                     answer.status = ST_NO_MEMORY;
                  end else begin
                     pt_root[root] = {page[21:0], 10'b0} | 32'd1;
                     pt_slot[root] = pt_tables_used[3:0];
                     leaf_at = {pt_tables_used[3:0], item.virtual_address[21:PAGE_SHIFT]};
                     pt_tables_used++;
                     ready = 1'b1;
                  end
               end
               if (ready) begin
                  answer.entry_value = {2'b00, item.physical_address[31:PAGE_SHIFT], 10'b0}
                                       | {22'b0, item.flag_bits} | 32'd1;
                  pt_leaf[leaf_at] = answer.entry_value;
               end
            end
         end
         KIND_LOOKUP: begin
            if ((item.virtual_address[2:0] & ALIGN_MASK) != 0)
               answer.status = ST_UNALIGNED_VA;
            else if (!pt_root[root][0])
               answer.status = ST_NOT_MAPPED;
            else
               answer.entry_value = pt_leaf[leaf_at];
         end
         KIND_ALLOC: begin
            if (take_pages(32'(item.page_count), page))
               answer.allocated_address = page << PAGE_SHIFT;
            else
               answer.status = ST_NO_MEMORY;
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", answers_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_answer(input rsp_type got);
      rsp_type want;
      if (pending_answers.size() == 0) begin
         report_mismatch("result with nothing pending, entry_value", got.entry_value, '0);
      end else begin
         want = pending_answers.pop_front();
         if (got.entry_value !== want.entry_value)
            report_mismatch("entry_value", got.entry_value, want.entry_value);
         if (got.allocated_address !== want.allocated_address)
            report_mismatch("allocated_address", got.allocated_address, want.allocated_address);
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      answers_seen++;
   endtask

   // Everything is sampled at the rising edge, before any of this edge's updates land.
   always @(posedge clock) begin : monitor
      rsp_type predicted;
      if (reset) begin
         clear_tables();
      end else begin
         // A result always belongs to an older transfer than one accepted at this edge.
         if (rsp_valid) check_answer(rsp);
         if (csr_we) begin
            if (csr_index == CSR_HEAP_START) heap_first = csr_wdata[HEAP_START_W-1:0];
            else if (csr_index == CSR_HEAP_END) heap_limit = csr_wdata[HEAP_END_W-1:0];
         end
         if (start && !busy) begin
            predicted = page_table_step(req);
            pending_answers.push_back(pin_valid ? pin_rsp : predicted);
         end
      end
   end

   task automatic send_request(input req_type item, input bit pinned, input rsp_type answer);
      start <= 1'b1;
      req <= item;
      pin_valid <= pinned;
      pin_rsp <= answer;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_heap_reg(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_row(input logic [1:0] kind, input logic [31:0] va,
                                   input logic [31:0] pa, input logic [9:0] flags,
                                   input logic [10:0] count, input bit pinned,
                                   input logic [31:0] entry, input logic [2:0] status);
      stim_row_type row;
      row.item = '{kind: kind, virtual_address: va, physical_address: pa,
                   flag_bits: flags, page_count: count};
      row.pinned = pinned;
      row.answer = '{entry_value: entry, allocated_address: 32'd0, status: status};
      directed_rows.push_back(row);
   endfunction

   function automatic req_type make_item();
      req_type    item;
      int         roll;
      logic [9:0] root;
      logic [9:0] leaf;
      logic [11:0] offs;
      roll = $urandom_range(0, 99);
      if (roll < 40) item.kind = KIND_MAP;
      else if (roll < 75) item.kind = KIND_LOOKUP;
      else if (roll < 95) item.kind = KIND_ALLOC;
      else item.kind = KIND_UNUSED;
      // Most addresses fall on a few root slots so that tables fill and get reused.
      root = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                          : root_pick[$urandom_range(0, 23)];
      leaf = $urandom_range(0, 1) ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
      offs = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(0, 511)) << 3;
      item.virtual_address = {root, leaf, offs};
      if (item.kind == KIND_LOOKUP && mapped_vas.size() > 0 && $urandom_range(0, 9) < 6)
         item.virtual_address = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
      if ($urandom_range(0, 19) == 0) item.virtual_address = $urandom;
      item.physical_address = $urandom;
      if ($urandom_range(0, 9) != 0) item.physical_address[2:0] = 3'b000;
      item.flag_bits = 10'($urandom_range(0, 1023));
      roll = $urandom_range(0, 9);
      if (roll < 7) item.page_count = 11'($urandom_range(0, 8));
      else if (roll < 9) item.page_count = 11'($urandom_range(0, 1024));
      else item.page_count = 11'($urandom_range(0, 2047));
      if (item.kind == KIND_MAP && item.virtual_address[2:0] == 3'b000) begin
         mapped_vas.push_back(item.virtual_address);
         if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
      end
      return item;
   endfunction

   task automatic run_random(input int count);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            // Back-to-back bursts half of the time, otherwise a short gap.
            if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 7));
            burst_left = $urandom_range(1, 24);
         end
         if ($urandom_range(0, 199) == 0) wait_drained();
         send_request(make_item(), 1'b0, '0);
         burst_left--;
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 24; i++) root_pick[i] = 10'($urandom_range(0, 1023));

      add_row(KIND_LOOKUP, 32'h0000_0000, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0, ST_NOT_MAPPED);
      add_row(KIND_MAP, 32'h0000_0001, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0, ST_UNALIGNED_VA);
      add_row(KIND_MAP, 32'h0040_0000, 32'h4, 10'h0, 11'd0, 1'b1, 32'h0, ST_UNALIGNED_PA);
      add_row(KIND_MAP, 32'h0000_0007, 32'h7, 10'h0, 11'd0, 1'b1, 32'h0, ST_UNALIGNED_VA);
      add_row(KIND_LOOKUP, 32'h0000_0002, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0, ST_UNALIGNED_VA);
      add_row(KIND_MAP, 32'h0000_0000, 32'hFFFF_F000, 10'h3FF, 11'd0, 1'b1, 32'h3FFF_FFFF,
              ST_OK);
      add_row(KIND_LOOKUP, 32'h0000_0000, 32'h0, 10'h0, 11'd0, 1'b1, 32'h3FFF_FFFF, ST_OK);
      // Never-written leaf in a live table reads as zero with an ok status.
      add_row(KIND_LOOKUP, 32'h0000_1000, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0, ST_OK);
      add_row(KIND_LOOKUP, 32'h0000_0FF8, 32'h0, 10'h0, 11'd0, 1'b1, 32'h3FFF_FFFF, ST_OK);
      add_row(KIND_MAP, 32'hFFFF_FFF8, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0000_0001, ST_OK);
      add_row(KIND_LOOKUP, 32'hFFC0_0000, 32'h0, 10'h0, 11'd0, 1'b0, 32'h0, ST_OK);
      add_row(KIND_LOOKUP, 32'hFFFF_F000, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0000_0001, ST_OK);
      add_row(KIND_ALLOC, 32'h0, 32'h0, 10'h0, 11'd0, 1'b0, 32'h0, ST_OK);
      add_row(KIND_ALLOC, 32'h0, 32'h0, 10'h0, 11'd1, 1'b0, 32'h0, ST_OK);
      add_row(KIND_ALLOC, 32'h0, 32'h0, 10'h0, 11'd1024, 1'b0, 32'h0, ST_OK);
      add_row(KIND_ALLOC, 32'h0, 32'h0, 10'h0, 11'd2047, 1'b0, 32'h0, ST_OK);
      add_row(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 11'h7FF, 1'b1, 32'h0, ST_OK);
      add_row(KIND_MAP, 32'h0000_2000, 32'h1234_5000, 10'h155, 11'd0, 1'b0, 32'h0, ST_OK);
      add_row(KIND_MAP, 32'h0000_2000, 32'hABCD_E008, 10'h2AA, 11'd0, 1'b0, 32'h0, ST_OK);
      add_row(KIND_LOOKUP, 32'h0000_2000, 32'h0, 10'h0, 11'd0, 1'b0, 32'h0, ST_OK);
      // The earlier failed map at 32'h0040_0000 must not have claimed this root slot.
      add_row(KIND_LOOKUP, 32'h0040_0000, 32'h0, 10'h0, 11'd0, 1'b1, 32'h0, ST_NOT_MAPPED);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The clearing sweep after reset holds busy high, so the first transfer waits on it.
      foreach (directed_rows[i])
         send_request(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].answer);
      wait_drained();

      // Empty heap: allocations and new tables run out of memory.
      write_heap_reg(CSR_HEAP_START, '0);
      write_heap_reg(CSR_HEAP_END, '0);
      run_random(150);

      // Heap at the top of the page range, largest start to largest end; the table pool fills here.
      write_heap_reg(CSR_HEAP_START, CSR_DATA_W'(20'hFFFFF));
      write_heap_reg(CSR_HEAP_END, CSR_DATA_W'(21'h1FFFFF));
      run_random(600);

      // Tight heap with a full pool, so both failure kinds show up.
      write_heap_reg(CSR_HEAP_START, CSR_DATA_W'(100));
      write_heap_reg(CSR_HEAP_END,
                     CSR_DATA_W'((100 + 32'(pt_pages_used) + 3000 > 32'h1FFFFF) ? 32'h1FFFFF
                                  : 100 + 32'(pt_pages_used) + 3000));
      run_random(400);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("two_level_page_table_mapper regression: pass");
      end else begin
         $display("two_level_page_table_mapper regression: fail");
      end
      $finish;
   end

endmodule

@@ two_level_page_table_mapper.f @@
hw/rtl/tlpt_pkg.sv
hw/rtl/tlpt_ctrl.sv
hw/rtl/tlpt_datapath.sv
hw/rtl/two_level_page_table_mapper.sv
tb/two_level_page_table_mapper_tb.sv
